// ===== src/nq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_pkg: shared types and constants of the N-queens enumerator
// Holds field widths, the board size reset value and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nq_pkg;

    // Width of one column number and of the board size register.
    localparam int COL_W     = 4;
    localparam int BSIZE_W   = 4;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 4'd8;

    // Result layout: ten rows of four bits and a ten-bit solution count.
    localparam int OUT_ROWS  = 10;
    localparam int QCOLS_W   = OUT_ROWS * COL_W;
    localparam int SOLNUM_W  = 10;
    localparam logic [SOLNUM_W-1:0] SOLNUM_MAX = 10'd1023;

    // APB register map.
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic REG_IDX_BSIZE = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // drop the search and the solution count
        logic launch;      // set up the step loop for a new request
        logic step;        // one placement or retreat step
        logic give_empty;  // load an exhausted result without searching
    } nq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finished;    // the search has run out of solutions
        logic hit;         // all rows are placed: a solution stands
        logic dead;        // retreat from an empty board: search exhausted
    } nq_sts_t;

endpackage

// ===== src/nq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_ctrl: sequencing state machine of the N-queens enumerator
// Takes one request, drives the datapath step by step until a solution or
// the end of the search, then holds the result until it is transferred.
// ----------------------------------------------------------------------------
module nq_ctrl
    import nq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    restart,
    output logic    out_valid,
    input  logic    out_ready,
    input  nq_sts_t sts,
    output nq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LAUNCH = 2'd1;
    localparam logic [1:0] ST_STEP   = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clear  = restart;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                if (sts.finished)
                begin
                    cmd.give_empty = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    cmd.launch = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (sts.hit || sts.dead)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/nq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nq_dpath: backtracking datapath of the N-queens enumerator
// Keeps the placed queens and the column and diagonal occupancy masks, and
// performs at most one placement or one retreat per step command.
// ----------------------------------------------------------------------------
module nq_dpath
    import nq_pkg::*;
#(
    parameter int MAX_BOARD = 10,
    localparam int ROW_W    = $clog2(MAX_BOARD + 1),
    localparam int ADDR_W   = $clog2(MAX_BOARD),
    localparam int DIAGS    = 2 * MAX_BOARD - 1,
    localparam int DIAG_W   = $clog2(DIAGS),
    localparam int PACK_ROWS = (MAX_BOARD < OUT_ROWS) ? MAX_BOARD : OUT_ROWS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  nq_cmd_t             cmd,
    input  logic                cfg_clear,
    input  logic [ROW_W-1:0]    n,
    output nq_sts_t             sts,
    output logic                found,
    output logic [QCOLS_W-1:0]  queen_columns,
    output logic [SOLNUM_W-1:0] solution_number
);

    // Search state.
    logic [COL_W-1:0]     placed_reg [MAX_BOARD];
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_W-1:0]     start_reg, start_next;
    logic                 retreat_reg, retreat_next;
    logic [MAX_BOARD-1:0] col_reg, col_next;
    logic [DIAGS-1:0]     down_reg, down_next;
    logic [DIAGS-1:0]     up_reg, up_next;
    logic                 finished_reg, finished_next;
    logic [SOLNUM_W-1:0]  count_reg, count_next;

    // Result register.
    logic                 found_reg;
    logic [QCOLS_W-1:0]   qcols_reg;
    logic [SOLNUM_W-1:0]  solnum_reg;

    // Step decode and helpers.
    logic                 at_top;
    logic                 do_hit, do_dead, do_pop, do_place;
    logic [MAX_BOARD-1:0] free_cols;
    logic                 any_free;
    logic [COL_W-1:0]     pick;
    logic [ROW_W-1:0]     prow;
    logic [COL_W-1:0]     pcol;
    logic [ROW_W-1:0]     mrow;
    logic [COL_W-1:0]     mcol;
    logic [DIAG_W-1:0]    down_idx, up_idx;
    logic [SOLNUM_W-1:0]  count_inc;
    logic [QCOLS_W-1:0]   packed_cols;

    assign at_top   = (row_reg == n);
    assign do_hit   = cmd.step && !retreat_reg && at_top;
    assign do_dead  = cmd.step && retreat_reg && (row_reg == '0);
    assign do_pop   = cmd.step && retreat_reg && (row_reg != '0);
    assign do_place = cmd.step && !retreat_reg && !at_top && any_free;

    assign sts.finished = finished_reg;
    assign sts.hit      = !retreat_reg && at_top;
    assign sts.dead     = retreat_reg && (row_reg == '0);

    // Free squares of the current row at or right of the start column.
    always_comb
    begin
        int dsel;
        int usel;
        for (int c = 0; c < MAX_BOARD; c++)
        begin
            dsel = int'(row_reg) + int'(n) - 1 - c;
            usel = int'(row_reg) + c;
            free_cols[c] = (c < int'(n)) && (c >= int'(start_reg)) && !col_reg[c]
                           && !down_reg[DIAG_W'(dsel)] && !up_reg[DIAG_W'(usel)];
        end
    end

    // Leftmost free column.
    always_comb
    begin
        pick = '0;
        for (int c = MAX_BOARD - 1; c >= 0; c--)
        begin
            if (free_cols[c])
            begin
                pick = COL_W'(c);
            end
        end
    end

    assign any_free = |free_cols;

    // The queen that a retreat lifts, and the square that is marked or cleared.
    assign prow     = row_reg - 1'b1;
    assign pcol     = placed_reg[prow[ADDR_W-1:0]];
    assign mrow     = do_pop ? prow : row_reg;
    assign mcol     = do_pop ? pcol : pick;
    assign down_idx = DIAG_W'(int'(mrow) + int'(n) - 1 - int'(mcol));
    assign up_idx   = DIAG_W'(int'(mrow) + int'(mcol));

    assign count_inc = (count_reg == SOLNUM_MAX) ? count_reg : count_reg + 1'b1;

    // Pack the placed rows; rows at or above the board size read as zero.
    always_comb
    begin
        packed_cols = '0;
        for (int r = 0; r < PACK_ROWS; r++)
        begin
            if (r < int'(n))
            begin
                packed_cols[r*COL_W +: COL_W] = placed_reg[ADDR_W'(r)];
            end
        end
    end

    // Next values of the search state.
    always_comb
    begin
        row_next      = row_reg;
        start_next    = start_reg;
        retreat_next  = retreat_reg;
        col_next      = col_reg;
        down_next     = down_reg;
        up_next       = up_reg;
        finished_next = finished_reg;
        count_next    = count_reg;
        if (cfg_clear || cmd.clear)
        begin
            row_next      = '0;
            start_next    = '0;
            retreat_next  = 1'b0;
            col_next      = '0;
            down_next     = '0;
            up_next       = '0;
            finished_next = 1'b0;
            count_next    = '0;
        end
        else if (cmd.launch)
        begin
            retreat_next = at_top;
            start_next   = '0;
        end
        else
        begin
            // Placing sets the three marks and a retreat clears them.
            if (do_pop || do_place)
            begin
                col_next  = col_reg ^ (MAX_BOARD'(1) << mcol);
                down_next = down_reg ^ (DIAGS'(1) << down_idx);
                up_next   = up_reg ^ (DIAGS'(1) << up_idx);
            end
            if (do_pop)
            begin
                row_next     = prow;
                start_next   = ROW_W'(int'(pcol) + 1);
                retreat_next = 1'b0;
            end
            else if (do_place)
            begin
                row_next   = row_reg + 1'b1;
                start_next = '0;
            end
            else if (cmd.step && !retreat_reg && !at_top)
            begin
                retreat_next = 1'b1;
            end
            if (do_dead)
            begin
                finished_next = 1'b1;
            end
            if (do_hit)
            begin
                count_next = count_inc;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            start_reg    <= '0;
            retreat_reg  <= 1'b0;
            col_reg      <= '0;
            down_reg     <= '0;
            up_reg       <= '0;
            finished_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            start_reg    <= start_next;
            retreat_reg  <= retreat_next;
            col_reg      <= col_next;
            down_reg     <= down_next;
            up_reg       <= up_next;
            finished_reg <= finished_next;
            count_reg    <= count_next;
        end
    end

    // Column of each placed row.
    always_ff @(posedge clk)
    begin
        if (do_place)
        begin
            placed_reg[row_reg[ADDR_W-1:0]] <= pick;
        end
    end

    // Result register, loaded on a solution or on an exhausted search.
    always_ff @(posedge clk)
    begin
        if (do_hit)
        begin
            found_reg  <= 1'b1;
            qcols_reg  <= packed_cols;
            solnum_reg <= count_inc;
        end
        else if (do_dead || cmd.give_empty)
        begin
            found_reg  <= 1'b0;
            qcols_reg  <= '0;
            solnum_reg <= count_reg;
        end
    end

    assign found           = found_reg;
    assign queen_columns   = qcols_reg;
    assign solution_number = solnum_reg;

endmodule

// ===== src/n_queens_solution_enumerator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_unit: N-queens backtracking enumerator
// Returns the solutions of the N-queens puzzle one per request, in
// depth-first order with columns tried left to right.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid/in_ready, field
// restart) asks for the next solution; restart high first drops the search
// and the solution count. Each request gives exactly one result on the
// output channel (out_valid/out_ready): found, queen_columns (four bits per
// row, row zero lowest) and solution_number. After the last solution every
// request returns found low until a restart.
// Flow: after the transfer the block passes a launch state, then steps the
// datapath through each placement, each dead end and each retreat of the
// search; an already exhausted search goes from the launch state straight
// to the result. With a single step unit, one request is handled at a time,
// so in_ready is low from the transfer until the result is taken.
// The result is held while out_ready is low. Reset sets the board size to
// eight and clears the search. A write to board_size (APB, address 0) also
// clears the search; write it only while the block is idle.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator_unit
    import nq_pkg::*;
#(
    parameter int MAX_BOARD = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [QCOLS_W-1:0]  queen_columns,
    output logic [SOLNUM_W-1:0] solution_number
);

    localparam int ROW_W = $clog2(MAX_BOARD + 1);

    logic [BSIZE_W-1:0] bsize_reg;
    logic               cfg_wr;
    logic [ROW_W-1:0]   n;
    nq_cmd_t            cmd;
    nq_sts_t            sts;

    // Register port: one board size register at word zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_BSIZE);
    assign prdata = (paddr[2] == REG_IDX_BSIZE) ? APB_DW'(bsize_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg <= BSIZE_RESET;
        end
        else if (cfg_wr)
        begin
            bsize_reg <= pwdata[BSIZE_W-1:0];
        end
    end

    // Effective board size, held to the range one to MAX_BOARD.
    always_comb
    begin
        if (bsize_reg == '0)
        begin
            n = ROW_W'(1);
        end
        else if (int'(bsize_reg) > MAX_BOARD)
        begin
            n = ROW_W'(MAX_BOARD);
        end
        else
        begin
            n = ROW_W'(bsize_reg);
        end
    end

    nq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nq_dpath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_clear       (cfg_wr),
        .n               (n),
        .sts             (sts),
        .found           (found),
        .queen_columns   (queen_columns),
        .solution_number (solution_number)
    );

    // A request and a pending result never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // After a transfer in, no new request is taken until the result leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken during a search");

    // A solution always carries a nonzero solution number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (solution_number != '0))
        else $error("solution with zero solution number");

    // An exhausted result carries an empty board.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (queen_columns == '0))
        else $error("exhausted result with queens on the board");

endmodule

// ===== test/n_queens_solution_enumerator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_unit_tb: self-checking bench for the enumerator
// Runs a short table of directed requests and board size writes, then long
// stretches of random requests under three idling schemes. An in-bench
// backtracking search predicts each result that the table does not give;
// a monitor checks each output transfer against the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator_unit_tb;
    import nq_pkg::*;

    localparam int BOARD_MAX = 10;
    localparam logic [APB_AW-1:0] ADDR_BSIZE    = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic                found;
        logic [QCOLS_W-1:0]  cols;
        logic [SOLNUM_W-1:0] num;
    } solution_t;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] data;
        logic              restart_bit;
        logic              typed;
        solution_t         want;
    } script_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                restart = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                found;
    logic [QCOLS_W-1:0]  queen_columns;
    logic [SOLNUM_W-1:0] solution_number;

    n_queens_solution_enumerator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .restart         (restart),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .queen_columns   (queen_columns),
        .solution_number (solution_number)
    );

    always #4 clk = ~clk;

    // Predicted search state and board size register.
    logic [BSIZE_W-1:0]  bsize_reg;
    int                  queen_col [BOARD_MAX];
    int                  rows_placed;
    logic [9:0]          col_busy;
    logic [18:0]         down_busy;
    logic [18:0]         up_busy;
    bit                  search_done;
    int                  solutions_out;

    solution_t           pending_solutions [$];
    int                  error_count = 0;
    int                  send_idle = 0;
    int                  recv_idle = 0;

    function automatic int board_n();
        if (bsize_reg == 0) return 1;
        if (bsize_reg > BOARD_MAX) return BOARD_MAX;
        return int'(bsize_reg);
    endfunction

    function automatic void drop_search();
        for (int r = 0; r < BOARD_MAX; r++) queen_col[r] = 0;
        rows_placed   = 0;
        col_busy      = '0;
        down_busy     = '0;
        up_busy       = '0;
        search_done   = 1'b0;
        solutions_out = 0;
    endfunction

    function automatic void occupy(int r, int c, int n, bit on);
        col_busy[c]          = on;
        down_busy[r + n - 1 - c] = on;
        up_busy[r + c]       = on;
    endfunction

    function automatic bit square_open(int r, int c, int n);
        return !col_busy[c] && !down_busy[r + n - 1 - c] && !up_busy[r + c];
    endfunction

    // Depth-first search from where the last solution left off.
    function automatic bit search_next(int n);
        int  col_start;
        bit  back_up;
        int  c;
        col_start = 0;
        if (search_done) return 1'b0;
        if (rows_placed > n) rows_placed = n;
        back_up = (rows_placed == n);
        while (1) begin
            if (back_up) begin
                if (rows_placed == 0) begin
                    search_done = 1'b1;
                    return 1'b0;
                end
                rows_placed--;
                c = queen_col[rows_placed];
                occupy(rows_placed, c, n, 1'b0);
                col_start = c + 1;
                back_up = 1'b0;
            end
            if (rows_placed == n) return 1'b1;
            c = col_start;
            while (c < n && !square_open(rows_placed, c, n)) c++;
            if (c < n) begin
                queen_col[rows_placed] = c;
                occupy(rows_placed, c, n, 1'b1);
                rows_placed++;
                col_start = 0;
            end else begin
                back_up = 1'b1;
            end
        end
    endfunction

    // Works out the result of one request and updates the predicted state.
    function automatic solution_t next_solution(bit restart_bit);
        solution_t res;
        int        n;
        n   = board_n();
        res = '0;
        if (restart_bit) drop_search();
        if (search_next(n)) begin
            for (int r = 0; r < n && r < OUT_ROWS; r++)
                res.cols[4*r +: 4] = queen_col[r][3:0];
            if (solutions_out < SOLNUM_MAX) solutions_out++;
            res.found = 1'b1;
        end
        res.num = solutions_out[SOLNUM_W-1:0];
        return res;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Output monitor: every result transfer is matched against the oldest expected result.
    always @(posedge clk) begin : result_monitor
        solution_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_solutions.size() == 0) begin
                flag_error("result transfer with no request outstanding");
            end else begin
                want = pending_solutions.pop_front();
                if (found !== want.found || queen_columns !== want.cols ||
                    solution_number !== want.num)
                    flag_error($sformatf(
                        "expected found=%0b cols=%h num=%0d, got found=%0b cols=%h num=%0d",
                        want.found, want.cols, want.num,
                        found, queen_columns, solution_number));
            end
        end
    end

    // Receiver: random back-pressure at the current rate.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Reads a register and compares it with the predicted value.
    task automatic check_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
            flag_error($sformatf("register read at %0d: expected %h, got %h",
                                 addr, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Register write, mirrored into the predictor, then read back.
    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_BSIZE) begin
            bsize_reg = data[BSIZE_W-1:0];
            drop_search();
        end
        @(posedge clk);
        check_reg(ADDR_BSIZE, APB_DW'(bsize_reg));
    endtask

    // Holds off until every outstanding result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_solutions.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random sender gap; valid drops only when a gap is taken.
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    // One request transfer; the typed result replaces the prediction if given.
    task automatic send_request(bit restart_bit, bit typed, solution_t typed_res);
        solution_t res;
        sender_gap();
        in_valid <= 1'b1;
        restart  <= restart_bit;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        res = next_solution(restart_bit);
        pending_solutions = {pending_solutions, (typed ? typed_res : res)};
    endtask

    function automatic script_row_t ask(bit restart_bit);
        script_row_t row;
        row = '{ROW_REQUEST, ADDR_BSIZE, '0, restart_bit, 1'b0, '0};
        return row;
    endfunction

    function automatic script_row_t ask_exp(bit restart_bit, bit f,
                                            logic [QCOLS_W-1:0] cols,
                                            logic [SOLNUM_W-1:0] num);
        script_row_t row;
        row = '{ROW_REQUEST, ADDR_BSIZE, '0, restart_bit, 1'b1, '{f, cols, num}};
        return row;
    endfunction

    function automatic script_row_t set_reg(logic [APB_AW-1:0] addr,
                                            logic [APB_DW-1:0] data);
        script_row_t row;
        row = '{ROW_WRITE, addr, data, 1'b0, 1'b0, '0};
        return row;
    endfunction

    // Random runs: pick a board size, then a stream of mostly continuing requests.
    task automatic random_runs(int count);
        int          sent;
        int          run_len;
        int          pick;
        logic [3:0]  size;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 70)      size = 4'($urandom_range(8));
            else if (pick < 85) size = 4'd9;
            else                size = 4'($urandom_range(15, 10));
            drain();
            write_reg(ADDR_BSIZE, ($urandom & 32'hFFFF_FFF0) | APB_DW'(size));
            run_len = $urandom_range(100, 3);
            for (int i = 0; i < run_len && sent < count; i++) begin
                if ($urandom_range(99) < 3) drain();
                send_request($urandom_range(99) < 4, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Watchdog.
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Main sequence.
    initial begin : main_seq
        script_row_t script [$];
        int          wait_cycles;

        bsize_reg = BSIZE_RESET;
        drop_search();

        // Directed table: reset state, tiny and unsolvable boards, saturation,
        // the ignored register index, restarts and exhausted searches.
        script = {script, ask_exp(1'b0, 1'b1, 40'h00_3162_5740, 10'd1)};
        script = {script, ask(1'b0)};
        script = {script, ask_exp(1'b1, 1'b1, 40'h00_3162_5740, 10'd1)};
        script = {script, set_reg(ADDR_BSIZE, 32'd0)};
        script = {script, ask_exp(1'b0, 1'b1, 40'h0, 10'd1)};
        script = {script, ask_exp(1'b0, 1'b0, 40'h0, 10'd1)};
        script = {script, ask_exp(1'b0, 1'b0, 40'h0, 10'd1)};
        script = {script, ask_exp(1'b1, 1'b1, 40'h0, 10'd1)};
        script = {script, set_reg(ADDR_BSIZE, 32'd2)};
        script = {script, ask_exp(1'b0, 1'b0, 40'h0, 10'd0)};
        script = {script, set_reg(ADDR_BSIZE, 32'd3)};
        script = {script, ask_exp(1'b1, 1'b0, 40'h0, 10'd0)};
        script = {script, set_reg(ADDR_BSIZE, 32'd4)};
        script = {script, ask_exp(1'b0, 1'b1, 40'h00_0000_2031, 10'd1)};
        script = {script, set_reg(ADDR_UNMAPPED, 32'd7)};
        script = {script, ask_exp(1'b0, 1'b1, 40'h00_0000_1302, 10'd2)};
        script = {script, ask_exp(1'b0, 1'b0, 40'h0, 10'd2)};
        script = {script, ask_exp(1'b0, 1'b0, 40'h0, 10'd2)};
        script = {script, ask_exp(1'b1, 1'b1, 40'h00_0000_2031, 10'd1)};
        script = {script, set_reg(ADDR_BSIZE, 32'hFFFF_FFF5)};
        script = {script, ask_exp(1'b0, 1'b1, 40'h00_0003_1420, 10'd1)};
        script = {script, set_reg(ADDR_BSIZE, 32'd15)};
        script = {script, ask(1'b0)};
        script = {script, ask(1'b1)};
        script = {script, set_reg(ADDR_BSIZE, 32'd10)};
        script = {script, ask(1'b0)};
        script = {script, ask(1'b0)};
        script = {script, set_reg(ADDR_BSIZE, 32'd11)};
        script = {script, ask(1'b0)};

        send_idle = 34;
        recv_idle = 67;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reg(ADDR_BSIZE, APB_DW'(BSIZE_RESET));

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                drain();
                write_reg(script[i].addr, script[i].data);
            end else begin
                send_request(script[i].restart_bit, script[i].typed, script[i].want);
            end
        end

        // Sender sparse, receiver sparser.
        random_runs(350);

        // Sender sparser, receiver sparse.
        send_idle = 67;
        recv_idle = 34;
        random_runs(350);

        // Full rate: walk the largest board to exhaustion, then more random runs.
        send_idle = 0;
        recv_idle = 0;
        drain();
        write_reg(ADDR_BSIZE, 32'd10);
        for (int i = 0; i < 730; i++) send_request(1'b0, 1'b0, '0);
        random_runs(300);

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_solutions.size() != 0 && wait_cycles < 2_000_000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);

        if (error_count == 0 && pending_solutions.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
